// ----- rtl/ssvp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssvp_pkg
// Shared types, codes and sizes of the step/scan velocity planner.
// ----------------------------------------------------------------------------
package ssvp_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_CRUISE = 1'b0;
   localparam logic [30:0] CRUISE_RESET = 31'd65536;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_SCAN = 2'd2;

   localparam logic [5:0] MUL_STEPS  = 6'd33;
   localparam logic [5:0] SQRT_STEPS = 6'd33;
   localparam logic [5:0] DIV_STEPS  = 6'd31;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pos_axis;
      logic signed [31:0] pos_circ;
      logic signed [31:0] span_axis;
      logic signed [31:0] span_circ;
      logic [1:0]         plan_mode;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_axis;
      logic signed [31:0] vel_circ;
      logic               driving;
      logic               plan_active;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_CLEAR,
      OP_MUL_SQ_INIT,
      OP_MUL_VEL_INIT,
      OP_MUL_STEP,
      OP_ACC,
      OP_ARRIVE,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STORE,
      OP_OUT_ZERO,
      OP_OUT_DRIVE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] job;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       active;
      logic       arrive;
      logic       out_free;
   } status_type;

endpackage

// ----- rtl/ssvp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssvp_ctrl
// Sequencer: steps the shared multiplier, square root and divider per tick.
// ----------------------------------------------------------------------------
module ssvp_ctrl import ssvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_SQ_INIT, S_SQ_RUN, S_SQ_ACC, S_CMP, S_RT_INIT, S_RT_RUN,
      S_VM_INIT, S_VM_RUN, S_DV_INIT, S_DV_RUN, S_VSTORE, S_OUT_ZERO, S_OUT_DRIVE
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] job_ff, job_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 6'd1;
      job_in   = job_ff;
      cmd.op   = OP_NONE;
      cmd.job  = job_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.kind == KIND_START) begin
               cmd.op   = OP_START;
               state_in = S_OUT_ZERO;
            end else if (status.kind == KIND_CLEAR) begin
               cmd.op   = OP_CLEAR;
               state_in = S_OUT_ZERO;
            end else if (status.kind == KIND_TICK && status.active) begin
               job_in   = 2'd0;
               state_in = S_SQ_INIT;
            end else begin
               state_in = S_OUT_ZERO;
            end
         end
         S_SQ_INIT: begin
            cmd.op   = OP_MUL_SQ_INIT;
            cnt_in   = 6'd0;
            state_in = S_SQ_RUN;
         end
         S_SQ_RUN: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_ff == MUL_STEPS - 6'd1) state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op = OP_ACC;
            if (job_ff == 2'd3) begin
               state_in = S_CMP;
            end else begin
               job_in   = job_ff + 2'd1;
               state_in = S_SQ_INIT;
            end
         end
         S_CMP: begin
            if (status.arrive) begin
               cmd.op   = OP_ARRIVE;
               state_in = S_OUT_ZERO;
            end else begin
               state_in = S_RT_INIT;
            end
         end
         S_RT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = 6'd0;
            state_in = S_RT_RUN;
         end
         S_RT_RUN: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == SQRT_STEPS - 6'd1) begin
               job_in   = 2'd0;
               state_in = S_VM_INIT;
            end
         end
         S_VM_INIT: begin
            cmd.op   = OP_MUL_VEL_INIT;
            cnt_in   = 6'd0;
            state_in = S_VM_RUN;
         end
         S_VM_RUN: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_ff == MUL_STEPS - 6'd1) state_in = S_DV_INIT;
         end
         S_DV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = 6'd0;
            state_in = S_DV_RUN;
         end
         S_DV_RUN: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == DIV_STEPS - 6'd1) state_in = S_VSTORE;
         end
         S_VSTORE: begin
            cmd.op = OP_STORE;
            if (job_ff == 2'd1) begin
               state_in = S_OUT_DRIVE;
            end else begin
               job_in   = 2'd1;
               state_in = S_VM_INIT;
            end
         end
         S_OUT_ZERO: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT_ZERO;
               state_in = S_IDLE;
            end
         end
         S_OUT_DRIVE: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT_DRIVE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
         job_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
      end
   end

endmodule

// ----- rtl/ssvp_dpath.sv -----
// ----------------------------------------------------------------------------
// ssvp_dpath
// Segment state, shift-add multiplier, digit square root, restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module ssvp_dpath import ssvp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [30:0] cruise,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   req_type            item_ff;
   logic signed [31:0] st_a_ff, st_c_ff, en_a_ff, en_c_ff;
   logic [1:0]         mode_ff;
   logic               enabled_ff, fwd_ff;
   logic [65:0]        p_ff, acc_len_ff, acc_dist_ff;
   logic [32:0]        mcand_ff, root_ff;
   logic [34:0]        rem_ff;
   logic [30:0]        dq_ff;
   logic               sat_ff;
   logic signed [31:0] va_ff, vc_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               back;
   logic signed [32:0] da, dc, pda, pdc, sum_a, sum_c;
   logic [32:0]        sel_d, mag;
   logic [33:0]        madd;
   logic [36:0]        sq_t, sq_trial;
   logic               sq_ge;
   logic [34:0]        dv_t, dv_len;
   logic               dv_ge;
   logic [30:0]        q;
   logic               neg;
   logic signed [31:0] vel;
   logic signed [31:0] end_a, end_c;

   assign back = (mode_ff == MODE_SCAN) && !fwd_ff;
   assign da   = {en_a_ff[31], en_a_ff} - {st_a_ff[31], st_a_ff};
   assign dc   = {en_c_ff[31], en_c_ff} - {st_c_ff[31], st_c_ff};
   assign pda  = {item_ff.pos_axis[31], item_ff.pos_axis}
               - (back ? {en_a_ff[31], en_a_ff} : {st_a_ff[31], st_a_ff});
   assign pdc  = {item_ff.pos_circ[31], item_ff.pos_circ}
               - (back ? {en_c_ff[31], en_c_ff} : {st_c_ff[31], st_c_ff});

   always_comb begin
      case (cmd.job)
         2'd0:    sel_d = da;
         2'd1:    sel_d = dc;
         2'd2:    sel_d = pda;
         default: sel_d = pdc;
      endcase
      mag = sel_d[32] ? 33'(-sel_d) : sel_d;
   end

   assign sum_a = {item_ff.pos_axis[31], item_ff.pos_axis}
                + {item_ff.span_axis[31], item_ff.span_axis};
   assign sum_c = {item_ff.pos_circ[31], item_ff.pos_circ}
                + {item_ff.span_circ[31], item_ff.span_circ};
   assign end_a = (sum_a[32] != sum_a[31]) ? (sum_a[32] ? 32'sh80000000 : 32'sh7fffffff)
                                           : sum_a[31:0];
   assign end_c = (sum_c[32] != sum_c[31]) ? (sum_c[32] ? 32'sh80000000 : 32'sh7fffffff)
                                           : sum_c[31:0];

   assign madd     = {1'b0, p_ff[65:33]} + (p_ff[0] ? {1'b0, mcand_ff} : 34'd0);
   assign sq_t     = {rem_ff, acc_len_ff[65:64]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_t >= sq_trial);
   assign dv_t     = {rem_ff[33:0], dq_ff[30]};
   assign dv_len   = {2'b00, root_ff};
   assign dv_ge    = (dv_t >= dv_len);

   assign q   = sat_ff ? 31'h7fffffff : dq_ff;
   assign neg = (cmd.job[0] ? dc[32] : da[32]) != back;
   assign vel = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

   assign status.kind     = item_ff.kind;
   assign status.active   = enabled_ff && (mode_ff == MODE_STEP || mode_ff == MODE_SCAN);
   assign status.arrive   = (acc_dist_ff >= acc_len_ff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_a_ff    <= '0;
         st_c_ff    <= '0;
         en_a_ff    <= '0;
         en_c_ff    <= '0;
         mode_ff    <= MODE_NONE;
         enabled_ff <= 1'b0;
         fwd_ff     <= 1'b1;
      end else begin
         case (cmd.op)
            OP_START: begin
               st_a_ff    <= item_ff.pos_axis;
               st_c_ff    <= item_ff.pos_circ;
               en_a_ff    <= end_a;
               en_c_ff    <= end_c;
               mode_ff    <= item_ff.plan_mode;
               enabled_ff <= 1'b1;
               fwd_ff     <= 1'b1;
            end
            OP_CLEAR: begin
               st_a_ff    <= '0;
               st_c_ff    <= '0;
               en_a_ff    <= '0;
               en_c_ff    <= '0;
               mode_ff    <= MODE_NONE;
               enabled_ff <= 1'b0;
            end
            OP_ARRIVE: begin
               if (mode_ff == MODE_STEP) enabled_ff <= 1'b0;
               else fwd_ff <= !fwd_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: item_ff <= req_data;
         OP_MUL_SQ_INIT: begin
            mcand_ff <= mag;
            p_ff     <= {33'd0, mag};
         end
         OP_MUL_VEL_INIT: begin
            mcand_ff <= {2'b00, cruise};
            p_ff     <= {33'd0, mag};
         end
         OP_MUL_STEP: p_ff <= {madd, p_ff[32:1]};
         OP_ACC: begin
            case (cmd.job)
               2'd0:    acc_len_ff  <= p_ff;
               2'd1:    acc_len_ff  <= acc_len_ff + p_ff;
               2'd2:    acc_dist_ff <= p_ff;
               default: acc_dist_ff <= acc_dist_ff + p_ff;
            endcase
         end
         OP_SQRT_INIT: begin
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            rem_ff     <= sq_ge ? 35'(sq_t - sq_trial) : sq_t[34:0];
            root_ff    <= {root_ff[31:0], sq_ge};
            acc_len_ff <= {acc_len_ff[63:0], 2'b00};
         end
         OP_DIV_INIT: begin
            sat_ff <= (p_ff >= {2'b00, root_ff, 31'd0});
            rem_ff <= {3'b000, p_ff[62:31]};
            dq_ff  <= p_ff[30:0];
         end
         OP_DIV_STEP: begin
            rem_ff <= dv_ge ? (dv_t - dv_len) : dv_t;
            dq_ff  <= {dq_ff[29:0], dv_ge};
         end
         OP_STORE: begin
            if (cmd.job[0]) vc_ff <= vel;
            else va_ff <= vel;
         end
         OP_OUT_ZERO: begin
            rsp_ff.vel_axis    <= '0;
            rsp_ff.vel_circ    <= '0;
            rsp_ff.driving     <= 1'b0;
            rsp_ff.plan_active <= enabled_ff;
         end
         OP_OUT_DRIVE: begin
            rsp_ff.vel_axis    <= va_ff;
            rsp_ff.vel_circ    <= vc_ff;
            rsp_ff.driving     <= 1'b1;
            rsp_ff.plan_active <= enabled_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT_ZERO || cmd.op == OP_OUT_DRIVE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/step_scan_velocity_planner_unit.sv -----
// ----------------------------------------------------------------------------
// step_scan_velocity_planner_unit
// Step/scan velocity planner, signed Q16.16, with an APB-style register port.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_data and are taken when req_stall is low;
// each request gives exactly one response on rsp_valid/rsp_data, held while
// rsp_stall is high. One request is worked on at a time.
// Start, clear and idle requests go from the decode state straight to the
// response write. A tick with motion enabled runs four 33-step shift-add
// squarings and answers at once on arrival; otherwise a 33-step square root
// and two 33-step multiplies with 31-step divisions follow. The shift-add
// multiplier serves all six multiplies, and the root and the divider share
// one bit-serial unit. A finished response sits in an output register, so the next
// request is taken while it waits; a stalled response blocks only the next
// one from being written. Reset clears the segment, disables motion, sets the
// forward scan direction and loads cruise_speed with 1.0. cruise_speed sits at
// byte address 0.
// ----------------------------------------------------------------------------
module step_scan_velocity_planner_unit import ssvp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [30:0] cruise_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CRUISE) ? {1'b0, cruise_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_ff <= CRUISE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == CSR_IDX_CRUISE) begin
         cruise_ff <= csr_pwdata[30:0];
      end
   end

   ssvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssvp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cruise    (cruise_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sim/step_scan_velocity_planner_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_scan_velocity_planner_unit_test
// Self-checking bench for the step/scan velocity planner. A directed table
// covers reset, extremes, every request kind and plan mode, saturation and
// zero-length segments; random start/tick sequences follow under several
// cruise speeds. Every response is checked field by field against a table entry
// or a local planner model, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module step_scan_velocity_planner_unit_test;
   import ssvp_pkg::*;

   localparam logic [1:0] KIND_IDLE = 2'd3;
   localparam logic [1:0] MODE_FULL = 2'd3;
   localparam int SETTLE = 400;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type want;
   } plan_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   req_type req_data = '0;
   logic rsp_valid, rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   step_scan_velocity_planner_unit dut (.*);

   always #2 clock = ~clock;

   // planner model state
   logic [30:0] cruise;
   longint seg_sa, seg_sc, seg_ea, seg_ec;
   logic [1:0] act_mode;
   bit enabled, fwd;

   rsp_type want_q[$];
   int n_req, n_rsp, n_drive, n_arrive, mismatches;
   bit calm;
   plan_row_type rows[$];

   function automatic logic [65:0] dist_sq(longint a, longint b);
      logic [65:0] ma, mc;
      ma = a < 0 ? -a : a;
      mc = b < 0 ? -b : b;
      return ma * ma + mc * mc;
   endfunction

   function automatic logic [32:0] root_of(logic [65:0] v);
      logic [32:0] r, c;
      logic [67:0] cc;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         c = r | (33'd1 << b);
         cc = {35'b0, c} * {35'b0, c};
         if (cc <= {2'b0, v}) r = c;
      end
      return r;
   endfunction

   function automatic longint vel_part(longint d, logic [32:0] len, bit back);
      logic [63:0] q;
      logic [32:0] m;
      if (len == 0) return 0;
      m = 33'(d < 0 ? -d : d);
      q = ({33'b0, cruise} * {31'b0, m}) / {31'b0, len};
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return ((d < 0) != back) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type plan_next(req_type r);
      rsp_type o;
      longint pa, pc, da, dc, va, vc;
      logic [65:0] len_sq, got_sq;
      logic [32:0] len;
      bit back;
      pa = r.pos_axis;
      pc = r.pos_circ;
      va = 0;
      vc = 0;
      o = '0;
      if (r.kind == KIND_START) begin
         seg_sa = pa;
         seg_sc = pc;
         seg_ea = sat32(pa + longint'(r.span_axis));
         seg_ec = sat32(pc + longint'(r.span_circ));
         act_mode = r.plan_mode;
         enabled = 1;
         fwd = 1;
      end else if (r.kind == KIND_CLEAR) begin
         seg_sa = 0; seg_sc = 0; seg_ea = 0; seg_ec = 0;
         act_mode = MODE_NONE;
         enabled = 0;
      end else if (r.kind == KIND_TICK && enabled &&
                   (act_mode == MODE_STEP || act_mode == MODE_SCAN)) begin
         da = seg_ea - seg_sa;
         dc = seg_ec - seg_sc;
         back = act_mode == MODE_SCAN && !fwd;
         len_sq = dist_sq(da, dc);
         got_sq = back ? dist_sq(pa - seg_ea, pc - seg_ec)
                       : dist_sq(pa - seg_sa, pc - seg_sc);
         if (got_sq >= len_sq) begin
            n_arrive++;
            if (act_mode == MODE_STEP) enabled = 0;
            else fwd = !fwd;
         end else begin
            len = root_of(len_sq);
            va = vel_part(da, len, back);
            vc = vel_part(dc, len, back);
            o.driving = 1;
            n_drive++;
         end
      end
      o.vel_axis = va[31:0];
      o.vel_circ = vc[31:0];
      o.plan_active = enabled;
      return o;
   endfunction

   function automatic int gap_len();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 88) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   task automatic send(req_type r, bit known = 0, rsp_type want = '0);
      rsp_type p;
      int g;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = plan_next(r);
      want_q.push_back(known ? want : p);
      n_req++;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (want_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_cruise(logic [30:0] v);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {CSR_IDX_CRUISE, 2'b00};
      csr_pwdata <= {1'b0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      cruise = v;
   endtask

   function automatic req_type mk(logic [1:0] k, logic [31:0] pa, logic [31:0] pc,
                                  logic [31:0] sa, logic [31:0] sc, logic [1:0] m);
      req_type r;
      r.kind = k; r.pos_axis = pa; r.pos_circ = pc;
      r.span_axis = sa; r.span_circ = sc; r.plan_mode = m;
      return r;
   endfunction

   function automatic rsp_type stopped(bit act);
      rsp_type o;
      o = '0;
      o.plan_active = act;
      return o;
   endfunction

   task automatic add(req_type r, bit known = 0, bit act = 0);
      plan_row_type x;
      x.r = r;
      x.known = known;
      x.want = stopped(act);
      rows.push_back(x);
   endtask

   function automatic logic [31:0] rand_q();
      return $urandom >> $urandom_range(0, 24) ^ (($urandom & 1) ? 32'hFFFF_FFFF : 0);
   endfunction

   task automatic random_part(int n);
      req_type r;
      longint sa, sc, spa, spc, f;
      int steps, done;
      done = 0;
      while (done < n) begin
         if ($urandom_range(0, 9) == 0) begin
            r = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                   2'($urandom_range(0, 3)));
            send(r);
            done++;
         end else begin
            r = mk(KIND_START, rand_q(), rand_q(), rand_q(), rand_q(), MODE_STEP);
            f = $urandom_range(0, 9);
            r.plan_mode = f < 5 ? MODE_STEP : f < 9 ? MODE_SCAN : 2'($urandom_range(0, 3));
            sa = r.pos_axis; sc = r.pos_circ;
            spa = r.span_axis; spc = r.span_circ;
            send(r);
            done++;
            steps = $urandom_range(2, 12);
            for (int i = 0; i < steps; i++) begin
               f = $urandom_range(0, 10);
               r = mk(KIND_TICK, 32'(sa + spa * f / 8), 32'(sc + spc * f / 8),
                      $urandom, $urandom, 2'($urandom_range(0, 3)));
               if ($urandom_range(0, 29) == 0) r.kind = KIND_CLEAR;
               send(r);
               done++;
            end
         end
      end
   endtask

   // response side
   initial begin
      rsp_type w;
      int hold;
      bit held;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            n_rsp++;
            if (want_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               w = want_q.pop_front();
               if (rsp_data.vel_axis !== w.vel_axis || rsp_data.vel_circ !== w.vel_circ ||
                   rsp_data.driving !== w.driving ||
                   rsp_data.plan_active !== w.plan_active) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", w, rsp_data);
               end
            end
         end
         if (!held && n_req > 60) begin
            held = 1;
            hold = 1500;
         end else if (!calm && hold == 0 && $urandom_range(0, 199) == 0) begin
            hold = $urandom_range(20, 120);
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1;
         end else if (calm) rsp_stall <= 0;
         else rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      cruise = CRUISE_RESET;
      seg_sa = 0; seg_sc = 0; seg_ea = 0; seg_ec = 0;
      act_mode = MODE_NONE;
      enabled = 0;
      fwd = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE), 1, 0);
      add(mk(KIND_IDLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, MODE_FULL), 1, 0);
      add(mk(KIND_START, 0, 0, 32'h000A_0000, 0, MODE_STEP), 1, 1);
      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE));
      add(mk(KIND_TICK, 32'h0005_0000, 32'h0001_0000, 0, 0, MODE_NONE));
      add(mk(KIND_TICK, 32'h000A_0000, 0, 0, 0, MODE_NONE), 1, 0);
      add(mk(KIND_START, 32'h0001_0000, 32'h0001_0000, 32'hFFFD_0000, 32'h0004_0000,
             MODE_SCAN), 1, 1);
      add(mk(KIND_TICK, 0, 32'h0002_0000, 0, 0, MODE_NONE));
      add(mk(KIND_TICK, 32'hFFFE_0000, 32'h0005_0000, 0, 0, MODE_NONE), 1, 1);
      add(mk(KIND_TICK, 32'hFFFF_0000, 32'h0003_0000, 0, 0, MODE_NONE));
      add(mk(KIND_TICK, 32'h0001_0000, 32'h0001_0000, 0, 0, MODE_NONE), 1, 1);
      add(mk(KIND_TICK, 32'h0001_0000, 32'h0002_0000, 0, 0, MODE_NONE));
      add(mk(KIND_START, 0, 0, 32'h0001_0000, 0, MODE_FULL), 1, 1);
      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE), 1, 1);
      add(mk(KIND_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             MODE_NONE), 1, 1);
      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE), 1, 1);
      add(mk(KIND_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             MODE_STEP), 1, 1);
      add(mk(KIND_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, MODE_NONE), 1, 0);
      add(mk(KIND_START, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, MODE_STEP), 1, 1);
      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE));
      add(mk(KIND_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, MODE_NONE));
      add(mk(KIND_START, 32'h0003_0000, 32'h0003_0000, 0, 0, MODE_SCAN), 1, 1);
      add(mk(KIND_TICK, 32'h0003_0000, 32'h0003_0000, 0, 0, MODE_NONE), 1, 1);
      add(mk(KIND_CLEAR, 32'h1234_5678, 0, 0, 0, MODE_SCAN), 1, 0);
      add(mk(KIND_TICK, 0, 0, 0, 0, MODE_NONE), 1, 0);
      foreach (rows[i]) send(rows[i].r, rows[i].known, rows[i].want);
      drain();

      // the long receiver hold lands in this first random part, once 60 requests are sent
      set_cruise(31'h7FFF_FFFF);
      random_part(250);
      drain();
      set_cruise(31'd0);
      random_part(150);
      drain();
      set_cruise(31'd1);
      calm = 1;
      random_part(150);
      drain();
      calm = 0;
      set_cruise(31'($urandom));
      random_part(300);
      drain();
      set_cruise(31'($urandom_range(0, 31'h0010_0000)));
      random_part(250);
      drain();

      $display("%0d requests, %0d responses: %0d drive ticks, %0d arrivals",
               n_req, n_rsp, n_drive, n_arrive);
      $display("cruise speeds swept from zero to full scale, %0d mismatches", mismatches);
      if (mismatches == 0 && want_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ssvp_pkg.sv
rtl/ssvp_ctrl.sv
rtl/ssvp_dpath.sv
rtl/step_scan_velocity_planner_unit.sv
sim/step_scan_velocity_planner_unit_test.sv
